// ===== rtl/fpa_pkg.sv =====
// Shared types, constants and saturation helper for the Q24.8 ALU.
// No dependencies; every rtl file refers to it by scoped names.
package fpa_pkg;

  localparam int W         = 32;              // word width
  localparam int F         = 8;               // fraction bits
  localparam int DVD_W     = W + F;           // dividend / quotient width
  localparam int DIV_STEP  = 2;               // quotient bits per divider stage
  localparam int DIV_STAGES = DVD_W / DIV_STEP;
  localparam int LATENCY   = DIV_STAGES + 3;  // front + multiply + divider + back

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_MIN      = 4'd4,
    OP_MAX      = 4'd5,
    OP_INC      = 4'd6,
    OP_DEC      = 4'd7,
    OP_TO_INT   = 4'd8,
    OP_FROM_INT = 4'd9
  } op_e;

  // Sideband that rides along with each request.
  typedef struct packed {
    logic             valid;
    logic [3:0]       op;
    logic             neg;      // sign of the mul/div result
    logic             na;       // sign of operand_a
    logic             less;
    logic             equal;
    logic             greater;
    logic             ovf;      // from_int saturation
    logic [W-1:0]     simple;   // result of the ops done in the front stage
    logic [2*W-1:0]   prod;     // |a| * |b|
  } ctrl_t;

  // Restoring divider state.
  typedef struct packed {
    logic [W-1:0]     rem;
    logic [DVD_W-1:0] dvd;      // dividend shifting out, quotient shifting in
    logic [W-1:0]     dsr;      // |b|
  } div_t;

  typedef struct packed {
    logic         ovf;
    logic [W-1:0] val;
  } sat_t;

  // Apply sign to magnitude q and clamp to the word range.
  function automatic sat_t sat_signed(input logic neg, input logic [63:0] q);
    sat_t s;
    logic [63:0] pos_lim;
    logic [63:0] neg_lim;
    logic [63:0] nq;
    pos_lim = {{(64-W+1){1'b0}}, {(W-1){1'b1}}};
    neg_lim = pos_lim + 64'd1;
    nq = 64'd0 - q;
    s.ovf = 1'b0;
    if (!neg) begin
      if (q > pos_lim) begin
        s.ovf = 1'b1;
        s.val = pos_lim[W-1:0];
      end else begin
        s.val = q[W-1:0];
      end
    end else begin
      if (q > neg_lim) begin
        s.ovf = 1'b1;
        s.val = neg_lim[W-1:0];
      end else begin
        s.val = nq[W-1:0];
      end
    end
    return s;
  endfunction

endpackage

// ===== rtl/fpa_front.sv =====
// Input stage: compare flags, magnitudes, front-stage ops, divider setup.
// Depends on fpa_pkg.
module fpa_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  take,
  input  logic [3:0]            opcode,
  input  logic signed [31:0]    operand_a,
  input  logic signed [31:0]    operand_b,
  output fpa_pkg::ctrl_t        ctrl,
  output fpa_pkg::div_t         div
);

  fpa_pkg::ctrl_t     ctrl_next;
  fpa_pkg::div_t      div_next;
  fpa_pkg::sat_t      fi;
  fpa_pkg::ctrl_t     payload;
  logic               vld;
  logic [fpa_pkg::W-1:0] ma;
  logic [fpa_pkg::W-1:0] mb;
  logic               lt;
  logic               gt;

  always_comb begin
    lt = operand_a < operand_b;
    gt = operand_a > operand_b;
    ma = operand_a[31] ? (32'd0 - operand_a) : operand_a;
    mb = operand_b[31] ? (32'd0 - operand_b) : operand_b;
    fi = fpa_pkg::sat_signed(operand_a[31],
                             {{(64-fpa_pkg::DVD_W){1'b0}}, ma, {fpa_pkg::F{1'b0}}});

    ctrl_next         = '0;
    ctrl_next.valid   = take;
    ctrl_next.op      = opcode;
    ctrl_next.neg     = operand_a[31] ^ operand_b[31];
    ctrl_next.na      = operand_a[31];
    ctrl_next.less    = lt;
    ctrl_next.equal   = operand_a == operand_b;
    ctrl_next.greater = gt;
    case (fpa_pkg::op_e'(opcode))
      fpa_pkg::OP_ADD:      ctrl_next.simple = operand_a + operand_b;
      fpa_pkg::OP_SUB:      ctrl_next.simple = operand_a - operand_b;
      fpa_pkg::OP_MIN:      ctrl_next.simple = lt ? operand_a : operand_b;
      fpa_pkg::OP_MAX:      ctrl_next.simple = gt ? operand_a : operand_b;
      fpa_pkg::OP_INC:      ctrl_next.simple = operand_a + 32'sd1;
      fpa_pkg::OP_DEC:      ctrl_next.simple = operand_a - 32'sd1;
      fpa_pkg::OP_TO_INT:   ctrl_next.simple = operand_a >>> fpa_pkg::F;
      fpa_pkg::OP_FROM_INT: begin
        ctrl_next.simple = fi.val;
        ctrl_next.ovf    = fi.ovf;
      end
      default:              ctrl_next.simple = '0;
    endcase

    div_next.rem = '0;
    div_next.dvd = {ma, {fpa_pkg::F{1'b0}}};
    div_next.dsr = mb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= ctrl_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    payload <= ctrl_next;
    div     <= div_next;
  end

  always_comb begin
    ctrl       = payload;
    ctrl.valid = vld;
  end

endmodule

// ===== rtl/fpa_mul.sv =====
// Multiply stage: registered 32x32 magnitude product.
// Depends on fpa_pkg.
module fpa_mul (
  input  logic            clk,
  input  logic            rst,
  input  fpa_pkg::ctrl_t  ctrl_in,
  input  fpa_pkg::div_t   div_in,
  output fpa_pkg::ctrl_t  ctrl,
  output fpa_pkg::div_t   div
);

  fpa_pkg::ctrl_t ctrl_next;
  fpa_pkg::ctrl_t payload;
  logic           vld;

  always_comb begin
    ctrl_next      = ctrl_in;
    ctrl_next.prod = div_in.dvd[fpa_pkg::DVD_W-1:fpa_pkg::F] * div_in.dsr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= ctrl_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    payload <= ctrl_next;
    div     <= div_in;
  end

  always_comb begin
    ctrl       = payload;
    ctrl.valid = vld;
  end

endmodule

// ===== rtl/fpa_div_stage.sv =====
// One divider stage: DIV_STEP restoring quotient bits, then a register.
// Depends on fpa_pkg.
module fpa_div_stage (
  input  logic            clk,
  input  logic            rst,
  input  fpa_pkg::ctrl_t  ctrl_in,
  input  fpa_pkg::div_t   div_in,
  output fpa_pkg::ctrl_t  ctrl,
  output fpa_pkg::div_t   div
);

  fpa_pkg::div_t      div_next;
  fpa_pkg::ctrl_t     payload;
  logic               vld;
  logic [fpa_pkg::W:0] trial;
  logic               qbit;

  always_comb begin
    div_next = div_in;
    trial    = '0;
    qbit     = 1'b0;
    for (int k = 0; k < fpa_pkg::DIV_STEP; k++) begin
      trial = {div_next.rem, div_next.dvd[fpa_pkg::DVD_W-1]};
      qbit  = trial >= {1'b0, div_next.dsr};
      if (qbit) begin
        trial = trial - {1'b0, div_next.dsr};
      end
      div_next.rem = trial[fpa_pkg::W-1:0];
      div_next.dvd = {div_next.dvd[fpa_pkg::DVD_W-2:0], qbit};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= ctrl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    payload <= ctrl_in;
    div     <= div_next;
  end

  always_comb begin
    ctrl       = payload;
    ctrl.valid = vld;
  end

endmodule

// ===== rtl/fpa_back.sv =====
// Output stage: rounding, saturation and result select, registered.
// Depends on fpa_pkg.
module fpa_back (
  input  logic                 clk,
  input  logic                 rst,
  input  fpa_pkg::ctrl_t       ctrl_in,
  input  fpa_pkg::div_t        div_in,
  output logic                 done,
  output logic [31:0]          result,
  output logic                 a_less,
  output logic                 a_equal,
  output logic                 a_greater,
  output logic                 overflow,
  output logic                 div_by_zero
);

  fpa_pkg::sat_t  ms;
  fpa_pkg::sat_t  ds;
  logic [63:0]    mq;
  logic [63:0]    dq;
  logic           rnd;
  logic           dz;
  logic [31:0]    res_next;
  logic           ovf_next;

  always_comb begin
    mq  = (ctrl_in.prod + (64'd1 << (fpa_pkg::F - 1))) >> fpa_pkg::F;
    ms  = fpa_pkg::sat_signed(ctrl_in.neg, mq);
    // round half away: remainder at least half the divisor
    rnd = {div_in.rem, 1'b0} >= {1'b0, div_in.dsr};
    dq  = {{(64-fpa_pkg::DVD_W){1'b0}}, div_in.dvd} + {63'd0, rnd};
    ds  = fpa_pkg::sat_signed(ctrl_in.neg, dq);
    dz  = div_in.dsr == '0;

    res_next = ctrl_in.simple;
    ovf_next = ctrl_in.ovf;
    case (fpa_pkg::op_e'(ctrl_in.op))
      fpa_pkg::OP_MUL: begin
        res_next = ms.val;
        ovf_next = ms.ovf;
      end
      fpa_pkg::OP_DIV: begin
        if (dz) begin
          res_next = ctrl_in.na ? {1'b1, {(fpa_pkg::W-1){1'b0}}}
                                : {1'b0, {(fpa_pkg::W-1){1'b1}}};
          ovf_next = 1'b1;
        end else begin
          res_next = ds.val;
          ovf_next = ds.ovf;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    result      <= res_next;
    a_less      <= ctrl_in.less;
    a_equal     <= ctrl_in.equal;
    a_greater   <= ctrl_in.greater;
    overflow    <= ovf_next;
    div_by_zero <= dz && (fpa_pkg::op_e'(ctrl_in.op) == fpa_pkg::OP_DIV);
  end

endmodule

// ===== rtl/fixed_point_q24_8_alu.sv =====
// Top level of the signed Q24.8 fixed-point ALU pipeline.
// Depends on fpa_pkg, fpa_front, fpa_mul, fpa_div_stage, fpa_back.
//
//  channel  | handshake     | payload
//  ---------+---------------+---------------------------------------------
//  request  | start / busy  | opcode, operand_a, operand_b
//  result   | done (strobe) | result, a_less, a_equal, a_greater,
//           |               | overflow, div_by_zero
//
// One request per cycle; every request, whatever its opcode, passes the
// same registers in order: front, multiply, 20 divider stages of two
// quotient bits each, output. The 40-bit restoring divide sets the depth.
// busy stays low: nothing in the pipe ever stalls, and the receiver cannot
// hold results off, so done is a one-cycle strobe.
// Synchronous reset clears only the valid bits; payload is don't-care.
module fixed_point_q24_8_alu (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         opcode,
  input  logic signed [31:0] operand_a,
  input  logic signed [31:0] operand_b,
  output logic               done,
  output logic signed [31:0] result,
  output logic               a_less,
  output logic               a_equal,
  output logic               a_greater,
  output logic               overflow,
  output logic               div_by_zero
);

  fpa_pkg::ctrl_t f_ctrl;
  fpa_pkg::div_t  f_div;
  // stage 0 is the multiply output, stage k the k-th divider output
  fpa_pkg::ctrl_t c_pipe [0:fpa_pkg::DIV_STAGES];
  fpa_pkg::div_t  d_pipe [0:fpa_pkg::DIV_STAGES];

  assign busy = 1'b0;

  fpa_front u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (start && !busy),
    .opcode    (opcode),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .ctrl      (f_ctrl),
    .div       (f_div)
  );

  fpa_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .ctrl_in (f_ctrl),
    .div_in  (f_div),
    .ctrl    (c_pipe[0]),
    .div     (d_pipe[0])
  );

  for (genvar g = 0; g < fpa_pkg::DIV_STAGES; g++) begin : g_div
    fpa_div_stage u_stage (
      .clk     (clk),
      .rst     (rst),
      .ctrl_in (c_pipe[g]),
      .div_in  (d_pipe[g]),
      .ctrl    (c_pipe[g+1]),
      .div     (d_pipe[g+1])
    );
  end

  fpa_back u_back (
    .clk         (clk),
    .rst         (rst),
    .ctrl_in     (c_pipe[fpa_pkg::DIV_STAGES]),
    .div_in      (d_pipe[fpa_pkg::DIV_STAGES]),
    .done        (done),
    .result      (result),
    .a_less      (a_less),
    .a_equal     (a_equal),
    .a_greater   (a_greater),
    .overflow    (overflow),
    .div_by_zero (div_by_zero)
  );

  // every accepted request is followed by a done strobe
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##23 done)
    else $error("request lost in pipeline");

  // exactly one compare flag per result
  a_cmp: assert property (@(posedge clk) disable iff (rst)
    done |-> $onehot({a_less, a_equal, a_greater}))
    else $error("compare flags not exclusive");

  // divide by zero always saturates
  a_dz: assert property (@(posedge clk) disable iff (rst)
    done && div_by_zero |-> overflow)
    else $error("div_by_zero without overflow");

endmodule

// ===== tb/tb_fixed_point_q24_8_alu.sv =====
// Self-checking testbench for the signed Q24.8 fixed-point ALU.
// Depends on fpa_pkg (opcode enum, LATENCY) and fixed_point_q24_8_alu.
module tb_fixed_point_q24_8_alu;

  // One expected outcome of an ALU request.
  typedef struct {
    logic [31:0] res;
    logic        lt;
    logic        eq;
    logic        gt;
    logic        ovf;
    logic        dz;
  } alu_out_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [3:0]         opcode;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;
  logic               done;
  logic signed [31:0] result;
  logic               a_less;
  logic               a_equal;
  logic               a_greater;
  logic               overflow;
  logic               div_by_zero;

  alu_out_t    pending_q[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit          random_gaps;

  localparam int unsigned CYCLE_LIMIT = 200000;

  fixed_point_q24_8_alu DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .opcode(opcode), .operand_a(operand_a), .operand_b(operand_b),
    .done(done), .result(result), .a_less(a_less), .a_equal(a_equal),
    .a_greater(a_greater), .overflow(overflow), .div_by_zero(div_by_zero)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Sign and clamp a magnitude into the 32-bit word.
  function automatic logic [31:0] clamp_word(input bit neg, input logic [63:0] mag,
                                             inout logic ovf);
    if (!neg) begin
      if (mag > 64'h7FFF_FFFF) begin
        ovf = 1'b1;
        return 32'h7FFF_FFFF;
      end
      return mag[31:0];
    end
    if (mag > 64'h8000_0000) begin
      ovf = 1'b1;
      return 32'h8000_0000;
    end
    return 32'd0 - mag[31:0];
  endfunction

  // Predict what the ALU gives for one request.
  function automatic alu_out_t alu_predict(input logic [3:0] op,
                                           input logic signed [31:0] a,
                                           input logic signed [31:0] b);
    alu_out_t    o;
    bit          na;
    bit          nb;
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] q;
    logic [63:0] n;
    na = a[31];
    nb = b[31];
    ma = na ? 64'd0 - {{32{a[31]}}, a} : {32'd0, a};
    mb = nb ? 64'd0 - {{32{b[31]}}, b} : {32'd0, b};
    o.res = '0;
    o.ovf = 1'b0;
    o.dz  = 1'b0;
    o.lt  = a < b;
    o.eq  = a == b;
    o.gt  = a > b;
    case (op)
      fpa_pkg::OP_ADD: o.res = a + b;
      fpa_pkg::OP_SUB: o.res = a - b;
      fpa_pkg::OP_MUL: begin
        q = (ma * mb + 64'd128) >> 8;
        o.res = clamp_word(na != nb, q, o.ovf);
      end
      fpa_pkg::OP_DIV: begin
        if (mb == 0) begin
          o.dz  = 1'b1;
          o.ovf = 1'b1;
          o.res = na ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
          n = ma << 8;
          q = (2 * n + mb) / (2 * mb);
          o.res = clamp_word(na != nb, q, o.ovf);
        end
      end
      fpa_pkg::OP_MIN: o.res = (a < b) ? a : b;
      fpa_pkg::OP_MAX: o.res = (a > b) ? a : b;
      fpa_pkg::OP_INC: o.res = a + 1;
      fpa_pkg::OP_DEC: o.res = a - 1;
      fpa_pkg::OP_TO_INT: o.res = a >>> 8;
      fpa_pkg::OP_FROM_INT: o.res = clamp_word(na, ma << 8, o.ovf);
      default: o.res = '0;
    endcase
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("MISMATCH %s: got %h expected %h at cycle %0d", what, got, want, cycles);
  endtask

  // Result checker: every done strobe is compared with the oldest expectation.
  always @(posedge clk) begin
    alu_out_t e;
    cycles <= cycles + 1;
    if (!rst && done) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result", result, 32'd0);
      end else begin
        e = pending_q.pop_front();
        if (result !== e.res) report_mismatch("result", result, e.res);
        if (a_less !== e.lt) report_mismatch("a_less", a_less, e.lt);
        if (a_equal !== e.eq) report_mismatch("a_equal", a_equal, e.eq);
        if (a_greater !== e.gt) report_mismatch("a_greater", a_greater, e.gt);
        if (overflow !== e.ovf) report_mismatch("overflow", overflow, e.ovf);
        if (div_by_zero !== e.dz) report_mismatch("div_by_zero", div_by_zero, e.dz);
      end
    end
  end

  // Hard stop if the pipe hangs.
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_fixed_point_q24_8_alu: FAIL");
      $finish;
    end
  end

  // Send one request; start stays high across back-to-back requests.
  task automatic send_request(input logic [3:0] op, input logic [31:0] a,
                              input logic [31:0] b);
    int gap;
    gap = random_gaps ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start     <= 1'b1;
    opcode    <= op;
    operand_a <= a;
    operand_b <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_q.push_back(alu_predict(op, a, b));
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000 + $urandom_range(0, 3);
      1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      2: return $urandom_range(0, 4) - 2;
      3: return {{16{1'b0}}, 16'($urandom)} << 8;
      4: return 32'($signed(16'($urandom)));
      default: return $urandom;
    endcase
  endfunction

  // Extremes, each opcode, and the named corner cases.
  task automatic test_directed();
    random_gaps = 1'b0;
    send_request(fpa_pkg::OP_ADD, 32'h7FFF_FFFF, 32'd1);
    send_request(fpa_pkg::OP_SUB, 32'h8000_0000, 32'd1);
    send_request(fpa_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000);
    send_request(fpa_pkg::OP_MUL, 32'h0000_0180, 32'hFFFF_FF80);
    send_request(fpa_pkg::OP_MUL, 32'd1, 32'h0000_0080);       // tie rounds away from zero
    send_request(fpa_pkg::OP_MUL, 32'hFFFF_FFFF, 32'h0000_0080);
    send_request(fpa_pkg::OP_DIV, 32'd5, 32'd0);               // divide by zero, positive
    send_request(fpa_pkg::OP_DIV, 32'hFFFF_FFFB, 32'd0);       // divide by zero, negative
    send_request(fpa_pkg::OP_DIV, 32'd0, 32'd0);
    send_request(fpa_pkg::OP_DIV, 32'h8000_0000, 32'hFFFF_FF00);
    send_request(fpa_pkg::OP_DIV, 32'h7FFF_FFFF, 32'd1);
    send_request(fpa_pkg::OP_DIV, 32'd1, 32'd2);
    send_request(fpa_pkg::OP_MIN, 32'd7, 32'd7);               // equal operands
    send_request(fpa_pkg::OP_MAX, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(fpa_pkg::OP_MIN, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(fpa_pkg::OP_INC, 32'h7FFF_FFFF, 32'd0);
    send_request(fpa_pkg::OP_DEC, 32'h8000_0000, 32'd0);
    send_request(fpa_pkg::OP_TO_INT, 32'hFFFF_FF01, 32'd0);
    send_request(fpa_pkg::OP_TO_INT, 32'h7FFF_FFFF, 32'd0);
    send_request(fpa_pkg::OP_FROM_INT, 32'h0080_0000, 32'd0);
    send_request(fpa_pkg::OP_FROM_INT, 32'hFF80_0000, 32'd0);
    send_request(fpa_pkg::OP_FROM_INT, 32'hFF7F_FFFF, 32'd0);
    send_request(4'd10, 32'd3, 32'd4);                         // unused opcodes
    send_request(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  // Random requests over all opcodes with random gaps and bursts.
  task automatic test_random(input int count);
    logic [31:0] a;
    logic [31:0] b;
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) random_gaps = ($urandom_range(0, 2) != 0);
      a = pick_operand();
      b = ($urandom_range(0, 9) == 0) ? a : pick_operand();
      send_request(4'($urandom_range(0, 15)), a, b);
    end
  endtask

  initial begin
    rst       = 1'b1;
    start     = 1'b0;
    opcode    = '0;
    operand_a = '0;
    operand_b = '0;
    random_gaps = 1'b0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_random(1330);
    start <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (fpa_pkg::LATENCY + 10) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb_fixed_point_q24_8_alu: PASS");
    end else begin
      $display("tb_fixed_point_q24_8_alu: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/fpa_pkg.sv
rtl/fpa_front.sv
rtl/fpa_mul.sv
rtl/fpa_div_stage.sv
rtl/fpa_back.sv
rtl/fixed_point_q24_8_alu.sv
tb/tb_fixed_point_q24_8_alu.sv
